[hdl/nprat_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprat_pkg
// Shared types and constants of the packet router with address table.
// ----------------------------------------------------------------------------
package nprat_pkg;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int QID_W = 8;

    localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};
    localparam logic [IP_W-1:0]  BCAST_IP  = {IP_W{1'b1}};

    // result kinds
    localparam logic [1:0] KIND_LOCAL   = 2'd0;
    localparam logic [1:0] KIND_LEARNED = 2'd1;
    localparam logic [1:0] KIND_DUP     = 2'd2;
    localparam logic [1:0] KIND_TX      = 2'd3;

    // register indexes (byte address bits [4:3])
    localparam logic [1:0] REG_OWN_IP  = 2'd0;
    localparam logic [1:0] REG_OWN_MAC = 2'd1;
    localparam logic [1:0] REG_ROLE    = 2'd2;

    // search token travelling along the cell chain
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [IP_W-1:0]  key;
        logic [MAC_W-1:0] mac;
    } token_t;

    // one result beat
    typedef struct packed {
        logic [1:0]       kind;
        logic [MAC_W-1:0] hop_mac;
        logic [IP_W-1:0]  dest_ip;
        logic [IP_W-1:0]  src_ip;
        logic             is_reply;
        logic             is_query;
        logic [QID_W-1:0] query_id;
        logic             counts_as_reply;
        logic             last_of_run;
    } res_t;

endpackage

[hdl/nprat_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprat_cell
// One table entry plus one stage of the search token chain.
// ----------------------------------------------------------------------------
module nprat_cell import nprat_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IP_W-1:0]  wr_ip,
    input  logic [MAC_W-1:0] wr_mac,
    input  logic             entry_on,
    input  token_t           tok_in,
    output token_t           tok_out
);

    logic [IP_W-1:0]  ip_reg;
    logic [MAC_W-1:0] mac_reg;
    logic             tok_valid_reg;
    logic             tok_hit_reg;
    logic [IP_W-1:0]  tok_key_reg;
    logic [MAC_W-1:0] tok_mac_reg;
    logic             match;

    // entry storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ip_reg  <= wr_ip;
            mac_reg <= wr_mac;
        end
    end

    // token stage, control part
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_in.valid;
        end
    end

    // token stage, payload part
    always_ff @(posedge clk)
    begin
        tok_hit_reg <= tok_in.hit;
        tok_key_reg <= tok_in.key;
        tok_mac_reg <= tok_in.mac;
    end

    // first match wins: an earlier hit passes through untouched
    assign match = entry_on && !tok_hit_reg && (ip_reg == tok_key_reg);

    always_comb
    begin
        tok_out.valid = tok_valid_reg;
        tok_out.hit   = tok_hit_reg || match;
        tok_out.key   = tok_key_reg;
        tok_out.mac   = match ? mac_reg : tok_mac_reg;
    end

endmodule

[hdl/nprat_chain.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nprat_chain
// Row of table cells; the search token moves one cell per cycle.
// ----------------------------------------------------------------------------
module nprat_chain import nprat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16,
    parameter int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_idx,
    input  logic [IP_W-1:0]  wr_ip,
    input  logic [MAC_W-1:0] wr_mac,
    input  logic [CNT_W-1:0] count,
    input  token_t           tok_in,
    output token_t           tok_out
);

    token_t link [TABLE_DEPTH+1];

    assign link[0] = tok_in;
    assign tok_out = link[TABLE_DEPTH];

    // one cell per entry
    for (genvar i = 0; i < TABLE_DEPTH; i++)
    begin : g_cell
        nprat_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .wr_en    (wr_en && (wr_idx == IDX_W'(i))),
            .wr_ip    (wr_ip),
            .wr_mac   (wr_mac),
            .entry_on (count > CNT_W'(i)),
            .tok_in   (link[i]),
            .tok_out  (link[i+1])
        );
    end

endmodule

[hdl/node_packet_router_arp_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// node_packet_router_arp_table
// Header router with an append-only IP-to-MAC table (restarted by each new query) and query suppression.
// ----------------------------------------------------------------------------
// One header is taken at a time; in_stall is high from the accept until the
// last result beat of that header has been loaded into the output register.
// Local delivery, learned replies and duplicate queries give one beat; a new
// query gives two beats on consecutive free output cycles (its reply MAC is
// the querier's own, just learned into entry zero). A forwarded packet sends
// a lookup token down the chain of TABLE_DEPTH cells, one cell per cycle, and
// its beat is built when the token leaves the last cell. Filtered packets give
// no beat. Configuration sits on an APB port, 64-bit data, registers at byte
// addresses 0 (own_ip), 8 (own_mac) and 16 (node_role).
// ----------------------------------------------------------------------------
module node_packet_router_arp_table import nprat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    // apb configuration
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [63:0]      pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    // header input
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [MAC_W-1:0] rx_dest_mac,
    input  logic [MAC_W-1:0] rx_src_mac,
    input  logic [IP_W-1:0]  rx_dest_ip,
    input  logic [IP_W-1:0]  rx_src_ip,
    input  logic             rx_is_reply,
    input  logic             rx_is_query,
    input  logic [QID_W-1:0] rx_query_id,
    // result output
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       result_kind,
    output logic [MAC_W-1:0] tx_dest_mac,
    output logic [IP_W-1:0]  tx_dest_ip,
    output logic [IP_W-1:0]  tx_src_ip,
    output logic             tx_is_reply,
    output logic             tx_is_query,
    output logic [QID_W-1:0] tx_query_id,
    output logic             counts_as_reply,
    output logic             last_of_run
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_SEND   = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [IP_W-1:0]  own_ip_reg;
    logic [MAC_W-1:0] own_mac_reg;
    logic             role_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [QID_W-1:0] last_query_reg, last_query_next;
    logic             two_reg, two_next;
    res_t             pend_reg, pend_next;
    res_t             out_reg;
    logic             out_valid_reg;

    logic [MAC_W-1:0] item_smac_reg;
    logic [IP_W-1:0]  item_dip_reg;
    logic [IP_W-1:0]  item_sip_reg;
    logic             item_rep_reg;
    logic             item_qry_reg;
    logic [QID_W-1:0] item_qid_reg;

    logic             cfg_wr;
    logic             accept;
    logic             mac_ok;
    logic             ip_own;
    logic             is_bq;
    logic             act_local;
    logic             act_dup;
    logic             act_query;
    logic             act_fwd;
    logic             full;
    logic             learn;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic             out_free;
    token_t           tok_in;
    token_t           tok_out;

    // ------------------------------------------------------------------
    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
            role_reg    <= 1'b0;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:3])
                REG_OWN_IP:  own_ip_reg  <= pwdata[IP_W-1:0];
                REG_OWN_MAC: own_mac_reg <= pwdata[MAC_W-1:0];
                REG_ROLE:    role_reg    <= pwdata[0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_OWN_IP:  prdata = {32'd0, own_ip_reg};
            REG_OWN_MAC: prdata = {16'd0, own_mac_reg};
            REG_ROLE:    prdata = {63'd0, role_reg};
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // header decision at accept
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign mac_ok = (rx_dest_mac == own_mac_reg) || (role_reg && (rx_dest_mac == BCAST_MAC));
    assign ip_own = (rx_dest_ip == own_ip_reg);
    assign is_bq  = (rx_dest_ip == BCAST_IP) && rx_is_query;

    assign act_local = mac_ok && ip_own;
    assign act_dup   = mac_ok && !ip_own && role_reg && is_bq && (rx_query_id == last_query_reg);
    assign act_query = mac_ok && !ip_own && role_reg && is_bq && (rx_query_id != last_query_reg);
    assign act_fwd   = mac_ok && !ip_own && role_reg && !is_bq;

    assign full  = (count_reg == CNT_W'(TABLE_DEPTH));
    assign learn = rx_is_reply && (act_local || act_fwd) && !full;

    // table write: a new query restarts the table at entry zero
    assign wr_en  = accept && (act_query || learn);
    assign wr_idx = act_query ? '0 : count_reg[IDX_W-1:0];

    always_comb
    begin
        tok_in.valid = accept && act_fwd;
        tok_in.hit   = 1'b0;
        tok_in.key   = rx_dest_ip;
        tok_in.mac   = rx_dest_mac;
    end

    nprat_chain #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_idx  (wr_idx),
        .wr_ip   (rx_src_ip),
        .wr_mac  (rx_src_mac),
        .count   (count_reg),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    // ------------------------------------------------------------------
    // sequencer
    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        last_query_next = last_query_reg;
        two_next        = two_reg;
        pend_next       = pend_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    two_next  = 1'b0;
                    if (act_query)
                    begin
                        count_next          = CNT_W'(1);
                        last_query_next     = rx_query_id;
                        two_next            = 1'b1;
                        pend_next.kind      = KIND_TX;
                        pend_next.hop_mac   = BCAST_MAC;
                        pend_next.dest_ip   = rx_dest_ip;
                        pend_next.src_ip    = rx_src_ip;
                        pend_next.is_reply  = rx_is_reply;
                        pend_next.is_query  = rx_is_query;
                        pend_next.query_id  = rx_query_id;
                        state_next          = ST_SEND;
                    end
                    else
                    begin
                        if (learn)
                        begin
                            count_next = count_reg + CNT_W'(1);
                        end
                        if (act_local)
                        begin
                            pend_next.kind            = rx_is_reply ? KIND_LEARNED : KIND_LOCAL;
                            pend_next.counts_as_reply = 1'b1;
                            pend_next.last_of_run     = 1'b1;
                            state_next                = ST_SEND;
                        end
                        else if (act_dup)
                        begin
                            pend_next.kind        = KIND_DUP;
                            pend_next.last_of_run = 1'b1;
                            state_next            = ST_SEND;
                        end
                        else if (act_fwd)
                        begin
                            state_next = ST_SEARCH;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (tok_out.valid)
                begin
                    pend_next.kind        = KIND_TX;
                    pend_next.hop_mac     = tok_out.mac;
                    pend_next.dest_ip     = item_dip_reg;
                    pend_next.src_ip      = item_sip_reg;
                    pend_next.is_reply    = item_rep_reg;
                    pend_next.is_query    = item_qry_reg;
                    pend_next.query_id    = item_qid_reg;
                    pend_next.last_of_run = 1'b1;
                    state_next            = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (out_free)
                begin
                    if (two_reg)
                    begin
                        // reply to the querier, whose entry sits at index zero
                        two_next                  = 1'b0;
                        pend_next                 = '0;
                        pend_next.kind            = KIND_TX;
                        pend_next.hop_mac         = item_smac_reg;
                        pend_next.dest_ip         = item_sip_reg;
                        pend_next.src_ip          = own_ip_reg;
                        pend_next.is_reply        = 1'b1;
                        pend_next.last_of_run     = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            last_query_reg <= '0;
            two_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            last_query_reg <= last_query_next;
            two_reg        <= two_next;
        end
    end

    // pending beat and held header fields
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (accept)
        begin
            item_smac_reg <= rx_src_mac;
            item_dip_reg  <= rx_dest_ip;
            item_sip_reg  <= rx_src_ip;
            item_rep_reg  <= rx_is_reply;
            item_qry_reg  <= rx_is_query;
            item_qid_reg  <= rx_query_id;
        end
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == ST_SEND && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SEND && out_free)
        begin
            out_reg <= pend_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result_kind     = out_reg.kind;
    assign tx_dest_mac     = out_reg.hop_mac;
    assign tx_dest_ip      = out_reg.dest_ip;
    assign tx_src_ip       = out_reg.src_ip;
    assign tx_is_reply     = out_reg.is_reply;
    assign tx_is_query     = out_reg.is_query;
    assign tx_query_id     = out_reg.query_id;
    assign counts_as_reply = out_reg.counts_as_reply;
    assign last_of_run     = out_reg.last_of_run;

    // ------------------------------------------------------------------
    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("table count beyond depth");

    a_token_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        tok_out.valid |-> (state_reg == ST_SEARCH))
        else $error("search token left chain outside search");

    a_query_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && act_query) |=> (count_reg == CNT_W'(1))
            && (last_query_reg == $past(rx_query_id)) && two_reg)
        else $error("new query did not restart table");

    a_second_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND && out_free && two_reg) |=>
            (state_reg == ST_SEND) && out_valid_reg && !out_reg.last_of_run)
        else $error("query reflood not followed by reply beat");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the packet router with address table: a scoreboard
// class predicts the result beats of each accepted header and checks every
// result beat in order, while plain tasks drive headers with random gaps and
// APB writes, and a receiver process drives random output stalls.
// ----------------------------------------------------------------------------
module tb import nprat_pkg::*;;

    localparam int TBL_DEPTH   = 16;
    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 300;

    // ------------------------------------------------------------------------
    // scoreboard: routing predictor and queue of expected result beats
    // ------------------------------------------------------------------------
    class route_scoreboard;
        logic [IP_W-1:0]  cfg_ip;
        logic [MAC_W-1:0] cfg_mac;
        logic             cfg_source;
        logic [IP_W-1:0]  tbl_ip  [TBL_DEPTH];
        logic [MAC_W-1:0] tbl_mac [TBL_DEPTH];
        int               tbl_count;
        logic [QID_W-1:0] last_qid;
        res_t             expected_beats[$];
        int               mismatches;

        function new();
            cfg_ip         = '0;
            cfg_mac        = '0;
            cfg_source     = 1'b0;
            tbl_count      = 0;
            last_qid       = '0;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                REG_OWN_IP:  cfg_ip     = value[IP_W-1:0];
                REG_OWN_MAC: cfg_mac    = value[MAC_W-1:0];
                REG_ROLE:    cfg_source = value[0];
                default: ;
            endcase
        endfunction

        // append-only; ignored once full
        function void learn(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac);
            if (tbl_count < TBL_DEPTH)
            begin
                tbl_ip[tbl_count]  = ip;
                tbl_mac[tbl_count] = mac;
                tbl_count++;
            end
        endfunction

        // first match from entry zero wins
        function logic [MAC_W-1:0] lookup(logic [IP_W-1:0] ip, logic [MAC_W-1:0] fallback);
            for (int i = 0; i < tbl_count; i++)
                if (tbl_ip[i] == ip)
                    return tbl_mac[i];
            return fallback;
        endfunction

        function void push_beat(logic [1:0] kind, logic [MAC_W-1:0] dmac,
                                logic [IP_W-1:0] dip, logic [IP_W-1:0] sip,
                                logic rep, logic qry, logic [QID_W-1:0] qid,
                                logic car, logic last);
            res_t b;
            b.kind            = kind;
            b.hop_mac         = dmac;
            b.dest_ip         = dip;
            b.src_ip          = sip;
            b.is_reply        = rep;
            b.is_query        = qry;
            b.query_id        = qid;
            b.counts_as_reply = car;
            b.last_of_run     = last;
            expected_beats.push_back(b);
        endfunction

        // routing decision for one accepted header
        function void note_header(logic [MAC_W-1:0] dmac, logic [MAC_W-1:0] smac,
                                  logic [IP_W-1:0] dip, logic [IP_W-1:0] sip,
                                  logic rep, logic qry, logic [QID_W-1:0] qid);
            // mac filter
            if (!(dmac == cfg_mac || (cfg_source && dmac == BCAST_MAC)))
                return;
            // addressed to this node, highest priority
            if (dip == cfg_ip)
            begin
                if (rep)
                begin
                    learn(sip, smac);
                    push_beat(KIND_LEARNED, '0, '0, '0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
                end
                else
                    push_beat(KIND_LOCAL, '0, '0, '0, 1'b0, 1'b0, '0, 1'b1, 1'b1);
                return;
            end
            if (!cfg_source)
                return;
            // discovery query, new or duplicate
            if (dip == BCAST_IP && qry)
            begin
                if (qid == last_qid)
                begin
                    push_beat(KIND_DUP, '0, '0, '0, 1'b0, 1'b0, '0, 1'b0, 1'b1);
                    return;
                end
                tbl_count = 0;
                learn(sip, smac);
                last_qid = qid;
                push_beat(KIND_TX, BCAST_MAC, dip, sip, rep, qry, qid, 1'b0, 1'b0);
                push_beat(KIND_TX, lookup(sip, '0), sip, cfg_ip, 1'b1, 1'b0, '0, 1'b0, 1'b1);
                return;
            end
            // forward with looked-up mac
            if (rep)
                learn(sip, smac);
            push_beat(KIND_TX, lookup(dip, dmac), dip, sip, rep, qry, qid, 1'b0, 1'b1);
        endfunction

        function string beat_str(res_t b);
            return $sformatf("kind=%0d dmac=%h dip=%h sip=%h rep=%b qry=%b qid=%h car=%b last=%b",
                             b.kind, b.hop_mac, b.dest_ip, b.src_ip, b.is_reply,
                             b.is_query, b.query_id, b.counts_as_reply, b.last_of_run);
        endfunction

        function void check_beat(res_t got);
            res_t want;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %s", beat_str(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.kind !== want.kind || got.hop_mac !== want.hop_mac ||
                got.dest_ip !== want.dest_ip || got.src_ip !== want.src_ip ||
                got.is_reply !== want.is_reply || got.is_query !== want.is_query ||
                got.query_id !== want.query_id ||
                got.counts_as_reply !== want.counts_as_reply ||
                got.last_of_run !== want.last_of_run)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %s", beat_str(want));
                    $display("  actual   %s", beat_str(got));
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic             clk;
    logic             rst_n;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [4:0]       paddr;
    logic [63:0]      pwdata;
    logic [63:0]      prdata;
    logic             pready;
    logic             in_valid;
    logic             in_stall;
    logic [MAC_W-1:0] rx_dest_mac;
    logic [MAC_W-1:0] rx_src_mac;
    logic [IP_W-1:0]  rx_dest_ip;
    logic [IP_W-1:0]  rx_src_ip;
    logic             rx_is_reply;
    logic             rx_is_query;
    logic [QID_W-1:0] rx_query_id;
    logic             out_valid;
    logic             out_stall;
    logic [1:0]       result_kind;
    logic [MAC_W-1:0] tx_dest_mac;
    logic [IP_W-1:0]  tx_dest_ip;
    logic [IP_W-1:0]  tx_src_ip;
    logic             tx_is_reply;
    logic             tx_is_query;
    logic [QID_W-1:0] tx_query_id;
    logic             counts_as_reply;
    logic             last_of_run;

    route_scoreboard  sb;
    bit               gaps_on;
    bit               hold_req;
    bit               hold_taken;
    int               hold_left;
    int               cycle_count;
    logic [IP_W-1:0]  ip_pool [12];

    node_packet_router_arp_table #(
        .TABLE_DEPTH (TBL_DEPTH)
    ) u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_dest_mac     (rx_dest_mac),
        .rx_src_mac      (rx_src_mac),
        .rx_dest_ip      (rx_dest_ip),
        .rx_src_ip       (rx_src_ip),
        .rx_is_reply     (rx_is_reply),
        .rx_is_query     (rx_is_query),
        .rx_query_id     (rx_query_id),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .result_kind     (result_kind),
        .tx_dest_mac     (tx_dest_mac),
        .tx_dest_ip      (tx_dest_ip),
        .tx_src_ip       (tx_src_ip),
        .tx_is_reply     (tx_is_reply),
        .tx_is_query     (tx_is_query),
        .tx_query_id     (tx_query_id),
        .counts_as_reply (counts_as_reply),
        .last_of_run     (last_of_run)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // monitor: note accepted headers, check accepted result beats
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_header(rx_dest_mac, rx_src_mac, rx_dest_ip, rx_src_ip,
                               rx_is_reply, rx_is_query, rx_query_id);
            if (out_valid && !out_stall)
            begin
                got.kind            = result_kind;
                got.hop_mac         = tx_dest_mac;
                got.dest_ip         = tx_dest_ip;
                got.src_ip          = tx_src_ip;
                got.is_reply        = tx_is_reply;
                got.is_query        = tx_is_query;
                got.query_id        = tx_query_id;
                got.counts_as_reply = counts_as_reply;
                got.last_of_run     = last_of_run;
                sb.check_beat(got);
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (hold_req && !hold_taken)
        begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            out_stall = 1'b1;
            hold_left--;
        end
        else
            out_stall = gaps_on && ($urandom_range(0, 99) < 13);
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[MAC_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------
    task automatic apb_write(logic [1:0] idx, logic [63:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // one header beat, held until accepted
    task automatic send_header(logic [MAC_W-1:0] dmac, logic [MAC_W-1:0] smac,
                               logic [IP_W-1:0] dip, logic [IP_W-1:0] sip,
                               logic rep, logic qry, logic [QID_W-1:0] qid);
        @(negedge clk);
        while (gaps_on && $urandom_range(0, 99) < 13)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        rx_dest_mac = dmac;
        rx_src_mac  = smac;
        rx_dest_ip  = dip;
        rx_src_ip   = sip;
        rx_is_reply = rep;
        rx_is_query = qry;
        rx_query_id = qid;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // wait until every expected beat is in and the block has gone quiet
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.expected_beats.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic configure(logic [IP_W-1:0] ip, logic [MAC_W-1:0] mac, logic source);
        drain();
        apb_write(REG_OWN_IP, {32'h0, ip});
        apb_write(REG_OWN_MAC, {16'h0, mac});
        apb_write(REG_ROLE, {63'h0, source});
    endtask

    // mostly well-formed headers aimed at this node or known addresses
    task automatic run_random(int target, int qpct);
        int               pick;
        logic [MAC_W-1:0] dmac;
        logic [IP_W-1:0]  dip;
        logic [IP_W-1:0]  sip;
        logic [QID_W-1:0] qid;
        for (int n = 0; n < target; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
                dmac = sb.cfg_mac;
            else if (pick < 85)
                dmac = BCAST_MAC;
            else
                dmac = rand_mac();
            pick = $urandom_range(0, 99);
            if (pick < 30)
                dip = sb.cfg_ip;
            else if (pick < 55)
                dip = BCAST_IP;
            else if (pick < 85)
                dip = ip_pool[$urandom_range(0, 11)];
            else
                dip = $urandom;
            sip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, 11)] : $urandom;
            qid = ($urandom_range(0, 1) != 0) ? QID_W'($urandom_range(0, 3)) : QID_W'($urandom);
            send_header(dmac, rand_mac(), dip, sip, $urandom_range(0, 99) < 40,
                        $urandom_range(0, 99) < qpct, qid);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [MAC_W-1:0] m;
        logic [IP_W-1:0]  a;
        logic [MAC_W-1:0] q_mac;
        logic [IP_W-1:0]  q_ip;
        sb          = new();
        gaps_on     = 1'b1;
        hold_req    = 1'b0;
        hold_taken  = 1'b0;
        hold_left   = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        out_stall   = 1'b0;
        rx_dest_mac = '0;
        rx_src_mac  = '0;
        rx_dest_ip  = '0;
        rx_src_ip   = '0;
        rx_is_reply = 1'b0;
        rx_is_query = 1'b0;
        rx_query_id = '0;
        foreach (ip_pool[i])
            ip_pool[i] = $urandom;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every routing case on a source node
        a     = 32'h0a00_0005;
        m     = 48'h0200_0000_0005;
        q_ip  = 32'h0a00_0009;
        q_mac = 48'h0200_0000_0009;
        configure(a, m, 1'b1);
        // query id zero straight after reset is a duplicate
        send_header(BCAST_MAC, q_mac, BCAST_IP, q_ip, 1'b0, 1'b1, 8'h00);
        send_header(m, 48'h0200_0000_0002, a, 32'h0a00_0002, 1'b0, 1'b0, 8'h00);
        send_header(m, 48'h0200_0000_0002, a, 32'h0a00_0002, 1'b1, 1'b0, 8'h00);
        send_header(BCAST_MAC, q_mac, BCAST_IP, q_ip, 1'b0, 1'b1, 8'h05);
        send_header(BCAST_MAC, q_mac, BCAST_IP, q_ip, 1'b0, 1'b1, 8'h05);
        send_header(m, 48'h1234_5678_9abc, q_ip, 32'h0a00_0003, 1'b0, 1'b0, 8'h00);
        send_header(m, 48'habcd_ef01_2345, 32'h0a00_00ee, 32'h0a00_0003, 1'b0, 1'b0, 8'h11);
        send_header(m, 48'h0a0b_0c0d_0e0f, q_ip, 32'h0a00_0044, 1'b1, 1'b0, 8'h07);
        send_header(m, 48'h0000_0000_0001, 32'h0a00_0044, q_ip, 1'b0, 1'b0, 8'h00);
        send_header(BCAST_MAC, 48'h0000_0000_0001, a, q_ip, 1'b0, 1'b0, 8'h00);
        send_header(48'h0, 48'h0000_0000_0001, a, q_ip, 1'b0, 1'b0, 8'h00);
        send_header(m, q_mac, 32'h0a00_0077, q_ip, 1'b0, 1'b1, 8'h09);
        send_header(BCAST_MAC, BCAST_MAC, BCAST_IP, 32'hffff_fffe, 1'b1, 1'b1, 8'hff);
        send_header(BCAST_MAC, BCAST_MAC, BCAST_IP, BCAST_IP, 1'b1, 1'b1, 8'hff);
        send_header(48'h0, 48'h0, 32'h0, 32'h0, 1'b0, 1'b0, 8'h00);
        send_header(m, 48'h0, 32'hffff_fffe, 32'h0, 1'b0, 1'b0, 8'h00);

        // random phases over several register settings
        configure($urandom, rand_mac(), 1'b0);
        run_random(281, 20);
        configure(32'h0, 48'h0, 1'b1);
        run_random(281, 30);
        // stretch with no idling on either side
        gaps_on = 1'b0;
        configure(BCAST_IP, BCAST_MAC, 1'b1);
        run_random(281, 30);
        gaps_on = 1'b1;
        // rare queries so the table fills, with a long receiver hold-off
        configure($urandom, rand_mac(), 1'b1);
        hold_req = 1'b1;
        run_random(281, 3);
        configure(BCAST_IP, 48'h0, 1'b0);
        run_random(281, 20);
        configure($urandom, rand_mac(), 1'b1);
        run_random(281, 15);

        drain();
        if (sb.mismatches == 0 && sb.expected_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
